// File: rtl/imsf_pkg.sv
// ----------------------------------------------------------------------------
// imsf_pkg
// Shared types, constants and helper functions of the Ising Metropolis core.
// ----------------------------------------------------------------------------
package imsf_pkg;

  localparam int LATTICE_SIDE = 64;
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int COORD_W      = (LATTICE_SIDE > 2) ? $clog2(LATTICE_SIDE) : 1;

  localparam int IN_COORD_W = 6;
  localparam int DRAW_W     = 32;
  localparam int THR_W      = 32;
  localparam int DE_W       = 5;
  localparam int ENERGY_W   = 15;
  localparam int MAGNET_W   = 14;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [THR_W-1:0] THR_FOUR_RESET  = THR_W'(78665069);
  localparam logic [THR_W-1:0] THR_EIGHT_RESET = THR_W'(1440801);

  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITE_COUNT);
  localparam logic signed [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(-SITE_COUNT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = CFG_IDX_W'(1);

  // item functions
  localparam logic FUNC_FLIP = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
  } cmd_t;

  // reduce an input coordinate onto the lattice by conditional subtraction
  function automatic logic [COORD_W-1:0] wrap_coord(input logic [IN_COORD_W-1:0] v);
    logic [IN_COORD_W+9:0] acc;
    logic [IN_COORD_W+9:0] step;
    acc = (IN_COORD_W+10)'(v);
    for (int i = IN_COORD_W - 1; i >= 0; i--) begin
      step = (IN_COORD_W+10)'(LATTICE_SIDE) << i;
      if (acc >= step) begin
        acc = acc - step;
      end
    end
    return COORD_W'(acc);
  endfunction

  function automatic logic [COORD_W-1:0] coord_plus(input logic [COORD_W-1:0] v);
    return (v == COORD_W'(LATTICE_SIDE - 1)) ? '0 : v + COORD_W'(1);
  endfunction

  function automatic logic [COORD_W-1:0] coord_minus(input logic [COORD_W-1:0] v);
    return (v == '0) ? COORD_W'(LATTICE_SIDE - 1) : v - COORD_W'(1);
  endfunction

endpackage

// File: rtl/imsf_ctrl.sv
// ----------------------------------------------------------------------------
// imsf_ctrl
// Item sequencer: load and first row reads, last row read, then execute.
// ----------------------------------------------------------------------------
module imsf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output imsf_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state != ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && start;
  assign cmd.fetch = (state == ST_FETCH);
  assign cmd.exec  = (state == ST_EXEC);

  a_load_then_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.fetch) else $error("fetch did not follow load");
  a_fetch_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> cmd.exec) else $error("exec did not follow fetch");
  a_exec_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !busy) else $error("still busy after exec");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping commands");

endmodule

// File: rtl/imsf_datapath.sv
// ----------------------------------------------------------------------------
// imsf_datapath
// Row-wide spin memory, neighbor rows, Metropolis decision and running totals.
// ----------------------------------------------------------------------------
module imsf_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  imsf_pkg::cmd_t                        cmd,
  input  logic                                  func,
  input  logic [imsf_pkg::IN_COORD_W-1:0]       row,
  input  logic [imsf_pkg::IN_COORD_W-1:0]       col,
  input  logic [imsf_pkg::DRAW_W-1:0]           random_draw,
  input  logic                                  spin_up,
  input  logic                                  cfg_we,
  input  logic [imsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [imsf_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  done,
  output logic                                  flipped,
  output logic signed [imsf_pkg::DE_W-1:0]      delta_energy,
  output logic signed [imsf_pkg::ENERGY_W-1:0]  total_energy,
  output logic signed [imsf_pkg::MAGNET_W-1:0]  magnetization,
  output logic [imsf_pkg::COUNT_W-1:0]          accepted_count
);

  localparam int SIDE = imsf_pkg::LATTICE_SIDE;
  localparam int CW   = imsf_pkg::COORD_W;

  // spin memory, one lattice row per word
  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] row_valid;

  logic [imsf_pkg::THR_W-1:0] thr_four;
  logic [imsf_pkg::THR_W-1:0] thr_eight;

  logic                         func_q;
  logic [CW-1:0]                row_q;
  logic [CW-1:0]                col_q;
  logic [imsf_pkg::DRAW_W-1:0]  draw_q;
  logic                         up_q;

  logic [CW-1:0]   addr_a;
  logic [CW-1:0]   addr_b;
  logic [CW-1:0]   row_in;
  logic [SIDE-1:0] rd_a;
  logic [SIDE-1:0] rd_b;
  logic [SIDE-1:0] row_cur;
  logic [SIDE-1:0] row_up;

  logic                                  spin;
  logic [2:0]                            up_count;
  logic signed [5:0]                     de_wide;
  logic signed [imsf_pkg::DE_W-1:0]      de;
  logic                                  flip;
  logic signed [imsf_pkg::DE_W-1:0]      reported;
  logic [SIDE-1:0]                       row_new;
  logic signed [imsf_pkg::ENERGY_W-1:0]  energy;
  logic signed [imsf_pkg::MAGNET_W-1:0]  magnet;
  logic [imsf_pkg::COUNT_W-1:0]          count;
  logic signed [imsf_pkg::ENERGY_W-1:0]  energy_next;
  logic signed [imsf_pkg::MAGNET_W-1:0]  magnet_next;
  logic [imsf_pkg::COUNT_W-1:0]          count_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_four  <= imsf_pkg::THR_FOUR_RESET;
      thr_eight <= imsf_pkg::THR_EIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imsf_pkg::CFG_THR_FOUR:  thr_four  <= imsf_pkg::THR_W'(cfg_data);
        imsf_pkg::CFG_THR_EIGHT: thr_eight <= imsf_pkg::THR_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      row_q  <= row_in;
      col_q  <= imsf_pkg::wrap_coord(col);
      draw_q <= random_draw;
      up_q   <= spin_up;
    end
  end

  // read addresses: own row and row above at load, row below at fetch
  always_comb begin
    row_in = imsf_pkg::wrap_coord(row);
    addr_a = cmd.load ? row_in : imsf_pkg::coord_plus(row_q);
    addr_b = imsf_pkg::coord_minus(row_in);
  end

  always_ff @(posedge clk) begin
    rd_a <= row_valid[addr_a] ? mem[addr_a] : '0;
    rd_b <= row_valid[addr_b] ? mem[addr_b] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      mem[row_q] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.exec) begin
      row_valid[row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      row_cur <= rd_a;
      row_up  <= rd_b;
    end
  end

  // decision, rd_a holds the row below during exec
  always_comb begin
    spin     = row_cur[col_q];
    up_count = 3'(row_cur[imsf_pkg::coord_plus(col_q)])
             + 3'(row_cur[imsf_pkg::coord_minus(col_q)])
             + 3'(row_up[col_q])
             + 3'(rd_a[col_q]);
    de_wide  = $signed({1'b0, up_count, 2'b00}) - 6'sd8;
    de       = spin ? imsf_pkg::DE_W'(de_wide) : imsf_pkg::DE_W'(-de_wide);

    if (func_q == imsf_pkg::FUNC_FLIP) begin
      if (de <= 0) begin
        flip = 1'b1;
      end else if (de == imsf_pkg::DE_W'(4)) begin
        flip = draw_q < thr_four;
      end else begin
        flip = draw_q < thr_eight;
      end
      reported = de;
    end else begin
      flip     = (spin != up_q);
      reported = flip ? de : '0;
    end

    row_new     = row_cur ^ (SIDE'(flip) << col_q);
    energy_next = flip ? energy + imsf_pkg::ENERGY_W'(de) : energy;
    magnet_next = !flip ? magnet
                : (spin ? magnet - imsf_pkg::MAGNET_W'(2) : magnet + imsf_pkg::MAGNET_W'(2));
    count_next  = (flip && func_q == imsf_pkg::FUNC_FLIP) ? count + 1'b1 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= imsf_pkg::ENERGY_RESET;
      magnet <= imsf_pkg::MAGNET_RESET;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        energy <= energy_next;
        magnet <= magnet_next;
        count  <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      flipped      <= flip;
      delta_energy <= reported;
    end
  end

  assign total_energy   = energy;
  assign magnetization  = magnet;
  assign accepted_count = count;

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec)) else $error("result without exec");
  a_count_on_flip: assert property (@(posedge clk) disable iff (rst)
    done && !flipped |-> $stable(accepted_count)) else $error("count moved on no flip");
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    done && !flipped |-> total_energy == $past(total_energy, 2))
    else $error("energy moved without flip");

endmodule

// File: rtl/ising_metropolis_spin_flip_core.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip_core
// Metropolis spin-flip engine on a periodic square lattice of one-bit spins.
//
//   channel  signals                                   direction
//   item     start, busy, func, row, col, random_draw,  in
//            spin_up
//   result   done, flipped, delta_energy,               out
//            total_energy, magnetization, accepted_count
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// an item passes the load, fetch and exec steps: three lattice rows are read
// through the two read ports of the row memory, the last in the cycle after
// the item is taken; the result strobe done is registered and comes in the
// cycle after the item ends, and a new item may start in that cycle
// reset clears the row valid bits at once, so no clearing pass is needed
// results cannot be held off; config writes are taken every cycle
// ----------------------------------------------------------------------------
module ising_metropolis_spin_flip_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  func,
  input  logic [imsf_pkg::IN_COORD_W-1:0]       row,
  input  logic [imsf_pkg::IN_COORD_W-1:0]       col,
  input  logic [imsf_pkg::DRAW_W-1:0]           random_draw,
  input  logic                                  spin_up,
  output logic                                  done,
  output logic                                  flipped,
  output logic signed [imsf_pkg::DE_W-1:0]      delta_energy,
  output logic signed [imsf_pkg::ENERGY_W-1:0]  total_energy,
  output logic signed [imsf_pkg::MAGNET_W-1:0]  magnetization,
  output logic [imsf_pkg::COUNT_W-1:0]          accepted_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [imsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [imsf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  imsf_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  imsf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  imsf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .func           (func),
    .row            (row),
    .col            (col),
    .random_draw    (random_draw),
    .spin_up        (spin_up),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .flipped        (flipped),
    .delta_energy   (delta_energy),
    .total_energy   (total_energy),
    .magnetization  (magnetization),
    .accepted_count (accepted_count)
  );

endmodule

// File: tb/ising_metropolis_spin_flip_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip_core_tb
// Self-checking bench for the Metropolis spin-flip core. A lattice model in a
// small class predicts every result from the accepted items and config
// writes, and compares it with what the core reports. A directed run walks
// the acceptance corners and wrap sites. Random runs then go over several
// threshold settings, with random gaps between items.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_flip_core_tb;
  import imsf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam logic [DRAW_W-1:0]    DRAW_ZERO    = '0;
  localparam logic [DRAW_W-1:0]    DRAW_FULL    = '1;

  typedef struct packed {
    logic                       flipped;
    logic signed [DE_W-1:0]     delta;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [MAGNET_W-1:0] magnet;
    logic [COUNT_W-1:0]         count;
  } site_result_t;

  class lattice_scoreboard;
    bit                 spin_grid [SITE_COUNT];
    int                 energy_sum;
    int                 magnet_sum;
    logic [COUNT_W-1:0] flips_taken;
    logic [THR_W-1:0]   bound_four;
    logic [THR_W-1:0]   bound_eight;
    site_result_t       outcome_q [$];
    int                 mismatches;

    function new();
      energy_sum  = -2 * SITE_COUNT;
      magnet_sum  = -SITE_COUNT;
      flips_taken = '0;
      bound_four  = THR_FOUR_RESET;
      bound_eight = THR_EIGHT_RESET;
      mismatches  = 0;
    endfunction

    function int spin_of(int r, int c);
      return spin_grid[r * LATTICE_SIDE + c] ? 1 : -1;
    endfunction

    function void set_bound(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_THR_FOUR) begin
        bound_four = THR_W'(val);
      end else if (idx == CFG_THR_EIGHT) begin
        bound_eight = THR_W'(val);
      end
    endfunction

    function void take_item(input logic fn, input logic [IN_COORD_W-1:0] r_in,
                            input logic [IN_COORD_W-1:0] c_in,
                            input logic [DRAW_W-1:0] draw, input logic up);
      int           r;
      int           c;
      int           s;
      int           nsum;
      int           de;
      bit           take;
      site_result_t want;
      r = int'(r_in) % LATTICE_SIDE;
      c = int'(c_in) % LATTICE_SIDE;
      s = spin_of(r, c);
      nsum = spin_of((r + 1) % LATTICE_SIDE, c)
           + spin_of((r + LATTICE_SIDE - 1) % LATTICE_SIDE, c)
           + spin_of(r, (c + 1) % LATTICE_SIDE)
           + spin_of(r, (c + LATTICE_SIDE - 1) % LATTICE_SIDE);
      de = 2 * s * nsum;
      if (fn == FUNC_FLIP) begin
        if (de <= 0) begin
          take = 1'b1;
        end else if (de == 4) begin
          take = draw < bound_four;
        end else begin
          take = draw < bound_eight;
        end
        if (take) begin
          flips_taken = flips_taken + 1'b1;
        end
      end else begin
        take = spin_grid[r * LATTICE_SIDE + c] != up;
      end
      if (take) begin
        spin_grid[r * LATTICE_SIDE + c] = !spin_grid[r * LATTICE_SIDE + c];
        energy_sum += de;
        magnet_sum -= 2 * s;
      end
      want.flipped = take;
      want.delta   = DE_W'((fn == FUNC_FLIP || take) ? de : 0);
      want.energy  = ENERGY_W'(energy_sum);
      want.magnet  = MAGNET_W'(magnet_sum);
      want.count   = flips_taken;
      outcome_q.push_back(want);
    endfunction

    function void check_outcome(input site_result_t got);
      site_result_t want;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: flipped=%0d de=%0d e=%0d m=%0d cnt=%0d",
                   got.flipped, $signed(got.delta), $signed(got.energy),
                   $signed(got.magnet), got.count);
        end
        return;
      end
      want = outcome_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected flipped=%0d de=%0d e=%0d m=%0d cnt=%0d",
                   $realtime, want.flipped, $signed(want.delta), $signed(want.energy),
                   $signed(want.magnet), want.count);
          $display("                 actual flipped=%0d de=%0d e=%0d m=%0d cnt=%0d",
                   got.flipped, $signed(got.delta), $signed(got.energy),
                   $signed(got.magnet), got.count);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst          = 1'b1;
  logic                       start        = 1'b0;
  logic                       busy;
  logic                       func         = FUNC_FLIP;
  logic [IN_COORD_W-1:0]      row          = '0;
  logic [IN_COORD_W-1:0]      col          = '0;
  logic [DRAW_W-1:0]          random_draw  = '0;
  logic                       spin_up      = 1'b0;
  logic                       done;
  logic                       flipped;
  logic signed [DE_W-1:0]     delta_energy;
  logic signed [ENERGY_W-1:0] total_energy;
  logic signed [MAGNET_W-1:0] magnetization;
  logic [COUNT_W-1:0]         accepted_count;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [CFG_DATA_W-1:0]      cfg_data     = '0;

  lattice_scoreboard sb = new();

  ising_metropolis_spin_flip_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .row            (row),
    .col            (col),
    .random_draw    (random_draw),
    .spin_up        (spin_up),
    .done           (done),
    .flipped        (flipped),
    .delta_energy   (delta_energy),
    .total_energy   (total_energy),
    .magnetization  (magnetization),
    .accepted_count (accepted_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_outcome('{flipped, delta_energy, total_energy, magnetization,
                           accepted_count});
      end
      if (start && !busy) begin
        sb.take_item(func, row, col, random_draw, spin_up);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_bound(cfg_index, cfg_data);
      end
    end
  end

  task automatic issue_item(input logic fn, input logic [IN_COORD_W-1:0] r,
                            input logic [IN_COORD_W-1:0] c,
                            input logic [DRAW_W-1:0] draw, input logic up);
    start       <= 1'b1;
    func        <= fn;
    row         <= r;
    col         <= c;
    random_draw <= draw;
    spin_up     <= up;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_thresholds(input logic [THR_W-1:0] four,
                                  input logic [THR_W-1:0] eight, input bit spare);
    if (spare) begin
      write_reg(CFG_SPARE_LO, $urandom());
      write_reg(CFG_SPARE_HI, $urandom());
    end
    write_reg(CFG_THR_FOUR, four);
    write_reg(CFG_THR_EIGHT, eight);
    if (spare) begin
      write_reg(CFG_SPARE_HI, $urandom());
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is back, then let the core idle
  task automatic settle();
    start <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [DRAW_W-1:0] pick_draw();
    int unsigned      k;
    logic [THR_W-1:0] bound;
    k = $urandom_range(0, 99);
    bound = $urandom_range(0, 1) ? sb.bound_four : sb.bound_eight;
    if (k < 15) begin
      return DRAW_ZERO;
    end else if (k < 25) begin
      return DRAW_FULL;
    end else if (k < 50) begin
      // around the acceptance bound
      return bound + DRAW_W'($urandom_range(0, 4)) - DRAW_W'(2);
    end
    return $urandom();
  endfunction

  task automatic run_random(input int count, input bit steady);
    int                    n;
    int unsigned           zone;
    logic [IN_COORD_W-1:0] r;
    logic [IN_COORD_W-1:0] c;
    for (n = 0; n < count; n++) begin
      if (!(steady && n >= 30 && n < 120) && $urandom_range(0, 99) < 32) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      zone = $urandom_range(0, 99);
      if (zone < 70) begin
        // window across the wrap corner
        r = IN_COORD_W'(62 + $urandom_range(0, 3));
        c = IN_COORD_W'(62 + $urandom_range(0, 3));
      end else if (zone < 80) begin
        r = IN_COORD_W'(30 + $urandom_range(0, 3));
        c = IN_COORD_W'(30 + $urandom_range(0, 3));
      end else begin
        r = IN_COORD_W'($urandom_range(0, 63));
        c = IN_COORD_W'($urandom_range(0, 63));
      end
      if ($urandom_range(0, 99) < 25) begin
        issue_item(FUNC_SET, r, c, $urandom(), 1'($urandom_range(0, 1)));
      end else begin
        issue_item(FUNC_FLIP, r, c, pick_draw(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at reset thresholds
    issue_item(FUNC_FLIP, 6'd0, 6'd0, DRAW_ZERO, 1'b0);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, DRAW_FULL, 1'b0);
    issue_item(FUNC_FLIP, 6'd63, 6'd63, DRAW_FULL, 1'b1);
    issue_item(FUNC_FLIP, 6'd63, 6'd63, THR_EIGHT_RESET, 1'b0);
    issue_item(FUNC_FLIP, 6'd63, 6'd63, THR_EIGHT_RESET - 1'b1, 1'b0);
    issue_item(FUNC_SET, 6'd63, 6'd63, DRAW_ZERO, 1'b0);
    issue_item(FUNC_SET, 6'd63, 6'd63, DRAW_FULL, 1'b0);
    issue_item(FUNC_SET, 6'd0, 6'd1, DRAW_ZERO, 1'b1);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, THR_FOUR_RESET, 1'b0);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, THR_FOUR_RESET - 1'b1, 1'b0);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, DRAW_FULL, 1'b0);
    issue_item(FUNC_SET, 6'd1, 6'd0, DRAW_ZERO, 1'b1);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, DRAW_FULL, 1'b0);
    issue_item(FUNC_SET, 6'd63, 6'd0, DRAW_ZERO, 1'b1);
    issue_item(FUNC_SET, 6'd0, 6'd63, DRAW_ZERO, 1'b1);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, DRAW_FULL, 1'b1);
    issue_item(FUNC_SET, 6'd0, 6'd0, DRAW_FULL, 1'b0);
    issue_item(FUNC_FLIP, 6'd0, 6'd0, DRAW_FULL, 1'b0);
    issue_item(FUNC_FLIP, 6'd32, 6'd31, $urandom(), 1'b1);
    issue_item(FUNC_SET, 6'd42, 6'd21, $urandom(), 1'b1);
    issue_item(FUNC_FLIP, 6'd21, 6'd42, DRAW_ZERO, 1'b0);
    settle();

    run_random(160, 1'b0);
    settle();

    apply_thresholds('0, '0, 1'b0);
    run_random(130, 1'b0);
    settle();

    apply_thresholds('1, '1, 1'b0);
    run_random(160, 1'b1);
    settle();

    apply_thresholds(THR_W'(32'h8000_0000), THR_W'(32'h2000_0000), 1'b1);
    run_random(160, 1'b0);
    settle();

    apply_thresholds($urandom(), $urandom(), 1'b1);
    run_random(100, 1'b0);
    settle();

    apply_thresholds(THR_FOUR_RESET, THR_EIGHT_RESET, 1'b0);
    run_random(90, 1'b0);
    settle();

    if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
      $display("ising_metropolis_spin_flip_core test passed");
    end else begin
      $display("ising_metropolis_spin_flip_core test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("ising_metropolis_spin_flip_core test failed");
    $finish;
  end

endmodule

// File: ising_metropolis_spin_flip_core.f
rtl/imsf_pkg.sv
rtl/imsf_ctrl.sv
rtl/imsf_datapath.sv
rtl/ising_metropolis_spin_flip_core.sv
tb/ising_metropolis_spin_flip_core_tb.sv
